[hw/rtl/hzp_pkg.sv]
// shared types and constants for the hierarchical z occlusion pyramid
`default_nettype none
package hzp_pkg;

  // default configuration
  localparam int unsigned SideLog2Def  = 6;
  localparam int unsigned DepthBitsDef = 24;

  // fixed port field widths
  localparam int unsigned OpW    = 2;
  localparam int unsigned PixW   = 6;
  localparam int unsigned DepthW = 24;
  localparam int unsigned CoordW = 12;

  // request operation codes
  typedef enum logic [OpW-1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_WRD,
    S_WCMP,
    S_UPRD,
    S_UPLAST,
    S_QRD,
    S_QCMP,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

[hw/rtl/hzp_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module hzp_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[hw/rtl/hierarchical_z_occlusion_pyramid.sv]
// top level: depth store and min pyramid in one ram, walked by a small sequencer
// clear pass: writes all (4^(SIDE_LOG2+1)-1)/3 ram entries (5461 by default) after reset and per clear request
// write: the pixel is read and depth tested; when the test passes, the pixel is written and each level is
//   rebuilt from 4 child reads and one node write on the single ram port pair
// query: one node read and compare per pyramid level visited
// one request at a time; the sequencer returns to idle before the next request is taken; a result
//   waits in the output register until taken
`default_nettype none
module hierarchical_z_occlusion_pyramid #(
  parameter int unsigned SIDE_LOG2  = hzp_pkg::SideLog2Def,
  parameter int unsigned DEPTH_BITS = hzp_pkg::DepthBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [hzp_pkg::OpW-1:0]       opcode_i,
  input  wire logic [hzp_pkg::PixW-1:0]      pixel_x_i,
  input  wire logic [hzp_pkg::PixW-1:0]      pixel_y_i,
  input  wire logic [hzp_pkg::DepthW-1:0]    depth_i,
  input  wire logic signed [hzp_pkg::CoordW-1:0] box_lo_x_i,
  input  wire logic signed [hzp_pkg::CoordW-1:0] box_lo_y_i,
  input  wire logic signed [hzp_pkg::CoordW-1:0] box_hi_x_i,
  input  wire logic signed [hzp_pkg::CoordW-1:0] box_hi_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               depth_written_o,
  output logic                               visible_o
);

  localparam int unsigned L     = SIDE_LOG2;
  localparam int unsigned DW    = DEPTH_BITS;
  localparam int unsigned AW    = 2 * L + 1;
  localparam int unsigned Total = ((1 << (2 * L + 2)) - 1) / 3;
  localparam int unsigned LW    = $clog2(L + 1);
  localparam int unsigned CW    = hzp_pkg::CoordW;
  localparam logic [AW-1:0] BasePat = AW'(Total);
  localparam logic [LW-1:0] LTop    = LW'(L);

  hzp_pkg::state_e state_q, state_d;
  hzp_pkg::op_e    op_in;
  logic [L-1:0]    x_q, x_d, y_q, y_d;
  logic [L-1:0]    lx_q, lx_d, ly_q, ly_d, hx_q, hx_d, hy_q, hy_d;
  logic            onscr_q, onscr_d;
  logic [DW-1:0]   d_q, d_d, min_q, min_d;
  logic [LW-1:0]   lvl_q, lvl_d;
  logic [1:0]      k_q, k_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic            rep_q, rep_d;
  logic            res_wr_q, res_wr_d, res_vis_q, res_vis_d;
  logic            out_valid_q, out_wr_q, out_vis_q;
  logic            load_out;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  // node address operands
  logic [LW-1:0] rd_lv, wr_lv, nxt_lv, sh_c, sh_p, sh_n;
  logic [L-1:0]  rd_cx, rd_cy, wr_cx, wr_cy;
  logic [L-1:0]  ch_x, ch_y;

  // input field widening and range checks
  logic [L+hzp_pkg::PixW-1:0]   px_ext, py_ext;
  logic [DW+hzp_pkg::DepthW-1:0] d_ext;
  logic in_on;

  assign px_ext = {{L{1'b0}}, pixel_x_i};
  assign py_ext = {{L{1'b0}}, pixel_y_i};
  assign d_ext  = {{DW{1'b0}}, depth_i};
  assign op_in  = hzp_pkg::op_e'(opcode_i);

  function automatic logic on_screen(input logic [CW-1:0] v);
    on_screen = !v[CW-1] && ((v[CW-2:0] >> L) == '0);
  endfunction

  function automatic logic [AW-1:0] node_addr(input logic [LW-1:0] lv,
                                               input logic [L-1:0] cx,
                                               input logic [L-1:0] cy);
    logic [AW-1:0] mask;
    mask = ~({AW{1'b1}} << {lv, 1'b0});
    node_addr = (BasePat & mask) + (AW'(cy) << lv) + AW'(cx);
  endfunction

  assign in_on = on_screen(box_lo_x_i) && on_screen(box_lo_y_i) &&
                 on_screen(box_hi_x_i) && on_screen(box_hi_y_i);

  // child coordinates one level below lvl_q for the upward walk
  assign sh_c = LTop - lvl_q - LW'(1);
  assign ch_x = ((x_q >> sh_c) & ~L'(1)) | L'(k_q[0]);
  assign ch_y = ((y_q >> sh_c) & ~L'(1)) | L'(k_q[1]);
  assign sh_p = LTop - lvl_q;
  assign nxt_lv = lvl_q + LW'(1);
  assign sh_n = LTop - nxt_lv;

  assign ram_raddr = node_addr(rd_lv, rd_cx, rd_cy);
  assign ram_waddr = ram_we && (state_q == hzp_pkg::S_CLR) ? cnt_q
                                                           : node_addr(wr_lv, wr_cx, wr_cy);

  hzp_ram #(
    .Width(DW),
    .Depth(Total)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state and datapath control
  always_comb begin
    state_d   = state_q;
    x_d = x_q; y_d = y_q; d_d = d_q;
    lx_d = lx_q; ly_d = ly_q; hx_d = hx_q; hy_d = hy_q; onscr_d = onscr_q;
    lvl_d = lvl_q; k_d = k_q; min_d = min_q; cnt_d = cnt_q; rep_d = rep_q;
    res_wr_d = res_wr_q; res_vis_d = res_vis_q;
    ram_we    = 1'b0;
    ram_wdata = '0;
    rd_lv = lvl_q; rd_cx = '0; rd_cy = '0;
    wr_lv = lvl_q; wr_cx = '0; wr_cy = '0;
    load_out = 1'b0;
    unique case (state_q)
      hzp_pkg::S_CLR: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + AW'(1);
        if (cnt_q == AW'(Total - 1)) begin
          state_d = rep_q ? hzp_pkg::S_DONE : hzp_pkg::S_IDLE;
        end
      end
      hzp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          x_d = px_ext[L-1:0]; y_d = py_ext[L-1:0]; d_d = d_ext[DW-1:0];
          lx_d = box_lo_x_i[L-1:0]; ly_d = box_lo_y_i[L-1:0];
          hx_d = box_hi_x_i[L-1:0]; hy_d = box_hi_y_i[L-1:0];
          onscr_d = in_on;
          lvl_d = '0; k_d = '0; cnt_d = '0; rep_d = 1'b1;
          res_wr_d = 1'b0; res_vis_d = 1'b0;
          unique case (op_in)
            hzp_pkg::OP_WRITE: state_d = hzp_pkg::S_WRD;
            hzp_pkg::OP_QUERY: state_d = hzp_pkg::S_QRD;
            hzp_pkg::OP_CLEAR: state_d = hzp_pkg::S_CLR;
            default:           state_d = hzp_pkg::S_DONE;
          endcase
        end
      end
      hzp_pkg::S_WRD: begin
        rd_lv = LTop; rd_cx = x_q; rd_cy = y_q;
        state_d = hzp_pkg::S_WCMP;
      end
      hzp_pkg::S_WCMP: begin
        if (d_q > ram_rdata) begin
          ram_we = 1'b1; ram_wdata = d_q;
          wr_lv = LTop; wr_cx = x_q; wr_cy = y_q;
          lvl_d = LTop - LW'(1); k_d = '0;
          state_d = hzp_pkg::S_UPRD;
        end else begin
          state_d = hzp_pkg::S_DONE;
        end
      end
      hzp_pkg::S_UPRD: begin
        rd_lv = nxt_lv; rd_cx = ch_x; rd_cy = ch_y;
        if (k_q == 2'd1) begin
          min_d = ram_rdata;
        end else if (k_q != 2'd0 && ram_rdata < min_q) begin
          min_d = ram_rdata;
        end
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = hzp_pkg::S_UPLAST;
        end
      end
      hzp_pkg::S_UPLAST: begin
        ram_we = 1'b1;
        ram_wdata = (ram_rdata < min_q) ? ram_rdata : min_q;
        wr_lv = lvl_q; wr_cx = x_q >> sh_p; wr_cy = y_q >> sh_p;
        k_d = '0;
        if (lvl_q == '0) begin
          res_wr_d = 1'b1;
          state_d  = hzp_pkg::S_DONE;
        end else begin
          lvl_d   = lvl_q - LW'(1);
          state_d = hzp_pkg::S_UPRD;
        end
      end
      hzp_pkg::S_QRD: begin
        rd_lv = lvl_q; rd_cx = lx_q >> sh_p; rd_cy = ly_q >> sh_p;
        state_d = hzp_pkg::S_QCMP;
      end
      hzp_pkg::S_QCMP: begin
        if (ram_rdata >= d_q) begin
          res_vis_d = 1'b0;
          state_d   = hzp_pkg::S_DONE;
        end else if (lvl_q == LTop || !onscr_q ||
                     (hx_q >> sh_n) != (lx_q >> sh_n) ||
                     (hy_q >> sh_n) != (ly_q >> sh_n)) begin
          res_vis_d = 1'b1;
          state_d   = hzp_pkg::S_DONE;
        end else begin
          lvl_d   = nxt_lv;
          state_d = hzp_pkg::S_QRD;
        end
      end
      hzp_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = hzp_pkg::S_IDLE;
        end
      end
      default: state_d = hzp_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hzp_pkg::S_CLR;
      cnt_q       <= '0;
      rep_q       <= 1'b0;
      lvl_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rep_q   <= rep_d;
      lvl_q   <= lvl_d;
      k_q     <= k_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; d_q <= d_d;
    lx_q <= lx_d; ly_q <= ly_d; hx_q <= hx_d; hy_q <= hy_d;
    onscr_q <= onscr_d; min_q <= min_d;
    res_wr_q <= res_wr_d; res_vis_q <= res_vis_d;
    if (load_out) begin
      out_wr_q  <= res_wr_q;
      out_vis_q <= res_vis_q;
    end
  end

  assign in_stall_o      = (state_q != hzp_pkg::S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign depth_written_o = out_wr_q;
  assign visible_o       = out_vis_q;

  // a result never claims both a stored write and a visible query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(depth_written_o && visible_o))
    else $error("write and query flags both set");

  // pyramid updates only touch internal nodes, never the pixel level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hzp_pkg::S_UPLAST) |-> (ram_waddr < AW'(((1 << (2 * L)) - 1) / 3)))
    else $error("pyramid write outside node range");

  // clear sweep stays inside the ram
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hzp_pkg::S_CLR) |-> (cnt_q < AW'(Total)))
    else $error("clear sweep out of range");

  // an accepted write request starts with the pixel read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && opcode_i == hzp_pkg::OP_WRITE)
      |=> (state_q == hzp_pkg::S_WRD))
    else $error("write request did not start pixel read");

endmodule
`default_nettype wire
